// ===== hw/rtl/mphq_pkg.sv =====
// Package for the max-priority heap queue unit.
// Holds the entry layout, operation and status codes and the sequencer state type.
// No dependencies.
package mphq_pkg;

  localparam logic [7:0] WATCH_RESET = 8'd5;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECOUNT,
    ST_UP_RD,
    ST_UP_CMP,
    ST_EX_RD,
    ST_EX_TOP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } state_e;

endpackage

// ===== hw/rtl/mphq_ram.sv =====
// Generic RAM: one synchronous write port, two read ports with registered data.
// No dependencies.
module mphq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hw/rtl/max_priority_heap_queue_unit.sv =====
// Max-priority heap queue: sequencer around the heap RAM, with a sift-up and a sift-down compare step.
// Insert climbs the new entry up from the last slot; extract moves the last entry to the root
// and sifts it down. A new beat is taken only when the sequencer is idle, not while one is in flight.
// A refused beat (full or empty) goes straight to the result.
// Reset clears counts and sequencer, not the RAM; a register write starts a recount of watched entries.
// Depends on mphq_pkg and mphq_ram.
module max_priority_heap_queue_unit #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  entry_priority_i,
  input  logic [15:0] entry_tag_i,
  // result channel
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  out_priority_o,
  output logic [15:0] out_tag_o,
  output logic [1:0]  status_o,
  output logic [6:0]  entry_count_o,
  output logic [6:0]  watched_count_o
);

  localparam int AW = $clog2(CAPACITY);      // heap index width
  localparam int CW = $clog2(CAPACITY + 1);  // count width, holds CAPACITY itself
  localparam int IW = AW + 2;                // child index width, holds 2*i+2

  // Sequencer and heap bookkeeping
  mphq_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;   // stored entries
  logic [CW-1:0]     wcnt_q, wcnt_d;     // entries matching the watched priority
  logic [7:0]        watched_q, watched_d;
  logic [AW-1:0]     hole_q, hole_d;     // index of the hole being sifted
  mphq_pkg::entry_t  move_q, move_d;     // entry travelling with the hole
  mphq_pkg::entry_t  top_q, top_d;       // extracted root
  logic              ext_q, ext_d;       // current beat is a successful extract
  mphq_pkg::status_e stat_q, stat_d;
  logic [CW-1:0]     rc_idx_q, rc_idx_d; // recount read pointer
  logic              rc_vld_q, rc_vld_d; // recount read data due this cycle

  // Result register
  logic              res_valid_q, res_valid_d;
  logic              res_ext_q, res_ext_d;
  mphq_pkg::entry_t  res_ent_q, res_ent_d;
  mphq_pkg::status_e res_stat_q, res_stat_d;
  logic [CW-1:0]     res_cnt_q, res_cnt_d;
  logic [CW-1:0]     res_wcnt_q, res_wcnt_d;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  mphq_pkg::entry_t  ram_wdata;
  logic [AW-1:0]     ram_raddr_a, ram_raddr_b;
  logic [$bits(mphq_pkg::entry_t)-1:0] ram_rdata_a, ram_rdata_b;
  mphq_pkg::entry_t  rd_a, rd_b;

  logic              accept;
  logic [AW-1:0]     parent;
  logic [IW-1:0]     left_idx, right_idx, n_ext;
  logic              left_ok, right_ok, sel_l, sel_r;
  logic [7:0]        best_prio;

  mphq_ram #(
    .WIDTH ($bits(mphq_pkg::entry_t)),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (ram_rdata_b)
  );

  assign rd_a = mphq_pkg::entry_t'(ram_rdata_a);
  assign rd_b = mphq_pkg::entry_t'(ram_rdata_b);

  assign in_stall_o = (state_q != mphq_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Tree navigation around the hole
  assign parent    = AW'((hole_q - AW'(1)) >> 1);
  assign left_idx  = (IW'(hole_q) << 1) + IW'(1);
  assign right_idx = (IW'(hole_q) << 1) + IW'(2);
  assign n_ext     = IW'(count_q);
  assign left_ok   = left_idx < n_ext;
  assign right_ok  = right_idx < n_ext;

  // Compare step for sift-down: left wins ties, swap only on strictly greater
  assign sel_l     = move_q.prio < rd_a.prio;
  assign best_prio = sel_l ? rd_a.prio : move_q.prio;
  assign sel_r     = right_ok && (best_prio < rd_b.prio);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    wcnt_d      = wcnt_q;
    watched_d   = watched_q;
    hole_d      = hole_q;
    move_d      = move_q;
    top_d       = top_q;
    ext_d       = ext_q;
    stat_d      = stat_q;
    rc_idx_d    = rc_idx_q;
    rc_vld_d    = 1'b0;
    res_valid_d = res_valid_q;
    res_ext_d   = res_ext_q;
    res_ent_d   = res_ent_q;
    res_stat_d  = res_stat_q;
    res_cnt_d   = res_cnt_q;
    res_wcnt_d  = res_wcnt_q;
    ram_we      = 1'b0;
    ram_waddr   = hole_q;
    ram_wdata   = move_q;
    ram_raddr_a = '0;
    ram_raddr_b = '0;

    // Drop the result once it has been taken
    if (res_valid_q && !res_stall_i) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      mphq_pkg::ST_IDLE: begin
        if (accept) begin
          stat_d = mphq_pkg::STAT_OK;
          ext_d  = 1'b0;
          if (func_i == mphq_pkg::FUNC_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              stat_d  = mphq_pkg::STAT_FULL;
              state_d = mphq_pkg::ST_DONE;
            end else begin
              move_d  = '{prio: entry_priority_i, tag: entry_tag_i};
              hole_d  = count_q[AW-1:0];
              count_d = count_q + CW'(1);
              if (entry_priority_i == watched_q) begin
                wcnt_d = wcnt_q + CW'(1);
              end
              state_d = mphq_pkg::ST_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              stat_d  = mphq_pkg::STAT_EMPTY;
              state_d = mphq_pkg::ST_DONE;
            end else begin
              ext_d   = 1'b1;
              count_d = count_q - CW'(1);
              state_d = mphq_pkg::ST_EX_RD;
            end
          end
        end
      end

      mphq_pkg::ST_RECOUNT: begin
        // Stream reads over the live entries and tally each match in the cycle after its read
        if (rc_idx_q < count_q) begin
          ram_raddr_a = rc_idx_q[AW-1:0];
          rc_idx_d    = rc_idx_q + CW'(1);
          rc_vld_d    = 1'b1;
        end else if (!rc_vld_q) begin
          state_d = mphq_pkg::ST_IDLE;
        end
        if (rc_vld_q && (rd_a.prio == watched_q)) begin
          wcnt_d = wcnt_q + CW'(1);
        end
      end

      mphq_pkg::ST_UP_RD: begin
        if (hole_q == '0) begin
          ram_we    = 1'b1;
          state_d   = mphq_pkg::ST_DONE;
        end else begin
          ram_raddr_a = parent;
          state_d     = mphq_pkg::ST_UP_CMP;
        end
      end

      mphq_pkg::ST_UP_CMP: begin
        ram_we = 1'b1;
        if (move_q.prio > rd_a.prio) begin
          // Pull the parent down into the hole and climb
          ram_wdata = rd_a;
          hole_d    = parent;
          state_d   = mphq_pkg::ST_UP_RD;
        end else begin
          state_d   = mphq_pkg::ST_DONE;
        end
      end

      mphq_pkg::ST_EX_RD: begin
        // Root on port A, last entry (index = new count) on port B
        ram_raddr_a = '0;
        ram_raddr_b = count_q[AW-1:0];
        state_d     = mphq_pkg::ST_EX_TOP;
      end

      mphq_pkg::ST_EX_TOP: begin
        top_d  = rd_a;
        move_d = rd_b;
        hole_d = '0;
        if (rd_a.prio == watched_q) begin
          wcnt_d = wcnt_q - CW'(1);
        end
        state_d = mphq_pkg::ST_DN_RD;
      end

      mphq_pkg::ST_DN_RD: begin
        if (!left_ok) begin
          ram_we  = 1'b1;
          state_d = mphq_pkg::ST_DONE;
        end else begin
          ram_raddr_a = left_idx[AW-1:0];
          ram_raddr_b = right_idx[AW-1:0];
          state_d     = mphq_pkg::ST_DN_CMP;
        end
      end

      mphq_pkg::ST_DN_CMP: begin
        ram_we = 1'b1;
        if (sel_r) begin
          ram_wdata = rd_b;
          hole_d    = right_idx[AW-1:0];
          state_d   = mphq_pkg::ST_DN_RD;
        end else if (sel_l) begin
          ram_wdata = rd_a;
          hole_d    = left_idx[AW-1:0];
          state_d   = mphq_pkg::ST_DN_RD;
        end else begin
          state_d   = mphq_pkg::ST_DONE;
        end
      end

      mphq_pkg::ST_DONE: begin
        // Hold until the result register is free
        if (!res_valid_q || !res_stall_i) begin
          res_valid_d = 1'b1;
          res_ext_d   = ext_q;
          res_ent_d   = ext_q ? top_q : '0;
          res_stat_d  = stat_q;
          res_cnt_d   = count_q;
          res_wcnt_d  = wcnt_q;
          state_d     = mphq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mphq_pkg::ST_IDLE;
      end
    endcase

    // A register write restarts the watched-count sweep
    if (cfg_we_i) begin
      watched_d = cfg_wdata_i;
      wcnt_d    = '0;
      rc_idx_d  = '0;
      rc_vld_d  = 1'b0;
      state_d   = mphq_pkg::ST_RECOUNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mphq_pkg::ST_IDLE;
      count_q     <= '0;
      wcnt_q      <= '0;
      watched_q   <= mphq_pkg::WATCH_RESET;
      rc_idx_q    <= '0;
      rc_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wcnt_q      <= wcnt_d;
      watched_q   <= watched_d;
      rc_idx_q    <= rc_idx_d;
      rc_vld_q    <= rc_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q     <= hole_d;
    move_q     <= move_d;
    top_q      <= top_d;
    ext_q      <= ext_d;
    stat_q     <= stat_d;
    res_ext_q  <= res_ext_d;
    res_ent_q  <= res_ent_d;
    res_stat_q <= res_stat_d;
    res_cnt_q  <= res_cnt_d;
    res_wcnt_q <= res_wcnt_d;
  end

  assign res_valid_o     = res_valid_q;
  assign out_valid_o     = res_ext_q;
  assign out_priority_o  = res_ent_q.prio;
  assign out_tag_o       = res_ent_q.tag;
  assign status_o        = res_stat_q;
  assign entry_count_o   = 7'(res_cnt_q);
  assign watched_count_o = 7'(res_wcnt_q);

  // Checks on the bookkeeping
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && (func_i == mphq_pkg::FUNC_INSERT) && (count_q != CW'(CAPACITY)))
    |=> (count_q == $past(count_q) + CW'(1)))
    else $error("accepted insert did not grow the heap");

  a_watched_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mphq_pkg::ST_IDLE) |-> (wcnt_q <= count_q))
    else $error("watched count above entry count");

  a_extract_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_valid_o) |-> (status_o == mphq_pkg::STAT_OK))
    else $error("extracted entry reported with refusal status");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((ram_waddr < count_q) || (count_q == '0)))
    else $error("heap write outside stored entries");

endmodule

// ===== verif/max_priority_heap_queue_checker.sv =====
// Checker for the max-priority heap queue: watches the input, result and configuration
// ports, keeps its own heap copy and compares every result beat field by field.
// Depends on mphq_pkg.
module max_priority_heap_queue_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  entry_priority_i,
  input  logic [15:0] entry_tag_i,
  input  logic        res_valid_o,
  input  logic        res_stall_i,
  input  logic        out_valid_o,
  input  logic [7:0]  out_priority_o,
  input  logic [15:0] out_tag_o,
  input  logic [1:0]  status_o,
  input  logic [6:0]  entry_count_o,
  input  logic [6:0]  watched_count_o,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mphq_pkg::*;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] prio;
    logic [15:0] tag;
    status_e    status;
    logic [6:0] count;
    logic [6:0] watched;
  } heap_reply_t;

  entry_t      heap_mem [CAPACITY];
  int          fill;
  logic [7:0]  watch;
  heap_reply_t queued_replies [$];
  int          mismatches = 0;

  // Apply one operation to the heap copy and return the reply it yields.
  function automatic heap_reply_t heap_step(func_e op, logic [7:0] pri, logic [15:0] tag);
    heap_reply_t r;
    entry_t      tmp;
    int          i, p, l, rc, big, n;
    r = '0;
    r.status = STAT_OK;
    if (op == FUNC_INSERT) begin
      if (fill >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        i = fill;
        heap_mem[i] = {pri, tag};
        fill++;
        // climb only on strictly greater priority
        while (i > 0) begin
          p = (i - 1) / 2;
          if (heap_mem[i].prio <= heap_mem[p].prio) break;
          tmp = heap_mem[i];
          heap_mem[i] = heap_mem[p];
          heap_mem[p] = tmp;
          i = p;
        end
      end
    end else if (fill == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.out_valid = 1'b1;
      r.prio = heap_mem[0].prio;
      r.tag  = heap_mem[0].tag;
      fill--;
      heap_mem[0] = heap_mem[fill];
      i = 0;
      // descend; left child wins a tie, swap only on strictly greater
      while (1) begin
        l   = 2 * i + 1;
        rc  = 2 * i + 2;
        big = i;
        if (l < fill && heap_mem[big].prio < heap_mem[l].prio) big = l;
        if (rc < fill && heap_mem[big].prio < heap_mem[rc].prio) big = rc;
        if (big == i) break;
        tmp = heap_mem[i];
        heap_mem[i] = heap_mem[big];
        heap_mem[big] = tmp;
        i = big;
      end
    end
    n = 0;
    for (int k = 0; k < fill; k++) begin
      if (heap_mem[k].prio == watch) n++;
    end
    r.count   = 7'(fill);
    r.watched = 7'(n);
    return r;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_reply_t want;
    if (!rst_ni) begin
      queued_replies.delete();
      fill  = 0;
      watch = WATCH_RESET;
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (res_valid_o && !res_stall_i) begin
        if (queued_replies.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none outstanding, expected nothing, got tag %0d",
                   $time, out_tag_o);
        end else begin
          want = queued_replies.pop_front();
          compare_field("out_valid", want.out_valid, out_valid_o);
          compare_field("out_priority", want.prio, out_priority_o);
          compare_field("out_tag", want.tag, out_tag_o);
          compare_field("status", want.status, status_o);
          compare_field("entry_count", want.count, entry_count_o);
          compare_field("watched_count", want.watched, watched_count_o);
        end
      end
      if (in_valid_i && !in_stall_o)
        queued_replies.push_back(heap_step(func_e'(func_i), entry_priority_i, entry_tag_i));
      if (cfg_we_i) watch = cfg_wdata_i;
      pending_o    <= queued_replies.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== verif/max_priority_heap_queue_unit_test.sv =====
// Top of the heap queue testbench: clock, reset, beat stimulus, result stalls and verdict.
// Prediction and checking live in max_priority_heap_queue_checker.
// Depends on mphq_pkg, max_priority_heap_queue_unit and max_priority_heap_queue_checker.
module max_priority_heap_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mphq_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 94;
  localparam int SETTLE      = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [7:0]  entry_priority_i = '0;
  logic [15:0] entry_tag_i = '0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic        out_valid_o;
  logic [7:0]  out_priority_o;
  logic [15:0] out_tag_o;
  logic [1:0]  status_o;
  logic [6:0]  entry_count_o;
  logic [6:0]  watched_count_o;

  int          fail_count;
  int          pending;
  int          cycles = 0;
  // Set during the calm phase: no input gaps and no result stalls.
  bit          calm = 1'b0;
  // Mirror of the watched priority, used only to aim stimulus at it.
  logic [7:0]  watch_now = WATCH_RESET;

  max_priority_heap_queue_unit #(.CAPACITY(CAPACITY)) dut (.*);

  max_priority_heap_queue_checker #(.CAPACITY(CAPACITY)) checker_inst (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Give up if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side at random, about 11 percent of the time, never in the calm phase.
  always @(posedge clk_i) begin
    res_stall_i <= !calm && ($urandom_range(99) < 11);
  end

  // Present one beat, idle at random first, and hold it until taken.
  // Valid stays high on return; the caller either sends again or drops it.
  task automatic send_op(input func_e op, input logic [7:0] pri, input logic [15:0] tag);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= op;
    entry_priority_i <= pri;
    entry_tag_i      <= tag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every outstanding result beat has come back.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Bias priorities towards the watched value, its neighbour and the extremes so
  // that ties and watched hits are common.
  function automatic logic [7:0] pick_priority();
    case ($urandom_range(9))
      0, 1:    return watch_now;
      2:       return 8'd0;
      3:       return 8'd255;
      4:       return watch_now ^ 8'h01;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [7:0] watch_plan [8];
    int         insert_pct [8];
    func_e      op;
    watch_plan = '{8'd255, 8'd0, 8'd5, 8'd0, 8'd128, 8'd255, 8'd7, 8'd1};
    insert_pct = '{80, 80, 20, 50, 80, 20, 75, 25};
    watch_plan[3] = 8'($urandom_range(255));
    watch_plan[6] = 8'($urandom_range(255));

    // Hold reset, then release it for good.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extract from empty, extreme fields, ties on the watched value and
    // on the root, then drain through the left-child tie rule and hit empty again.
    send_op(FUNC_EXTRACT, 8'd0, 16'h0000);
    send_op(FUNC_INSERT, 8'd0, 16'h0000);
    send_op(FUNC_INSERT, 8'd255, 16'hFFFF);
    send_op(FUNC_INSERT, 8'd5, 16'hAAAA);
    send_op(FUNC_INSERT, 8'd5, 16'h5555);
    send_op(FUNC_INSERT, 8'd255, 16'h0001);
    send_op(FUNC_INSERT, 8'd128, 16'h1234);
    send_op(FUNC_INSERT, 8'd5, 16'h0F0F);
    send_op(FUNC_INSERT, 8'd254, 16'h7FFF);
    send_op(FUNC_INSERT, 8'd5, 16'h8000);
    repeat (10) send_op(FUNC_EXTRACT, 8'd255, 16'hFFFF);
    send_op(FUNC_EXTRACT, 8'd255, 16'hFFFF);
    drain();

    // Random phases: mix fill-heavy, drain-heavy and balanced phases so the heap runs
    // into both full and empty; rewrite the watched priority between phases.
    for (int ph = 0; ph < 8; ph++) begin
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= watch_plan[ph];
      watch_now   <= watch_plan[ph];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      calm = (ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < insert_pct[ph]) ? FUNC_INSERT : FUNC_EXTRACT;
        send_op(op, pick_priority(), 16'($urandom_range(65535)));
      end
      drain();
      calm = 1'b0;
    end

    // Let any late beat show up before the verdict.
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
